// File: design/lc3_pkg.sv
// Shared types and constants for the 3D outcode line clipper.
`timescale 1ns / 1ps
package lc3_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int MAG_W       = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * COORD_WIDTH + 1;
    localparam int MUL_STEPS   = MAG_W;
    localparam int DIV_STEPS   = PROD_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int QMASK_W     = 62;
    localparam int SUM_W       = 64;
    localparam int MAX_PASSES  = 6;
    localparam int PASS_W      = 3;

    localparam logic [2:0] REG_X_MIN = 3'd0;
    localparam logic [2:0] REG_Y_MIN = 3'd1;
    localparam logic [2:0] REG_Z_MIN = 3'd2;
    localparam logic [2:0] REG_X_MAX = 3'd3;
    localparam logic [2:0] REG_Y_MAX = 3'd4;
    localparam logic [2:0] REG_Z_MAX = 3'd5;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        logic       load;
        logic       pick;
        logic       mul_start;
        logic       mul_step;
        logic       div_step;
        logic       store;
        logic       commit;
        logic       out_load;
        logic       acc;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic       all_in;
        logic       disjoint;
        logic       out_held;
        logic [1:0] ax;
    } t_sts;
endpackage

// File: design/lc3_dp.sv
// Datapath of the line clipper: endpoints, outcodes, serial multiply and divide, output word.
`timescale 1ns / 1ps
module lc3_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lc3_pkg::t_cmd        i_cmd,
    output lc3_pkg::t_sts        o_sts,
    input  lc3_pkg::t_coord      i_min [3],
    input  lc3_pkg::t_coord      i_max [3],
    input  lc3_pkg::t_coord      i_in0 [3],
    input  lc3_pkg::t_coord      i_in1 [3],
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic                 o_accepted,
    output lc3_pkg::t_coord      o_p0 [3],
    output lc3_pkg::t_coord      o_p1 [3]
);
    localparam int CW = lc3_pkg::COORD_WIDTH;
    localparam int MW = lc3_pkg::MAG_W;
    localparam int PW = lc3_pkg::PROD_W;
    localparam int SW = lc3_pkg::SUM_W;

    lc3_pkg::t_coord r_p0 [3];
    lc3_pkg::t_coord r_p1 [3];
    lc3_pkg::t_coord r_np [3];
    lc3_pkg::t_coord r_plane;
    logic            r_who;
    logic [1:0]      r_ax;
    logic signed [MW-1:0] r_num;
    logic [MW-1:0]   r_dax;
    logic [PW-1:0]   r_ma;
    logic [MW-1:0]   r_mb;
    logic [PW-1:0]   r_prod;
    logic [MW-1:0]   r_rem;
    logic            r_neg;
    logic            r_valid;
    logic            r_acc;
    lc3_pkg::t_coord r_o0 [3];
    lc3_pkg::t_coord r_o1 [3];

    lc3_pkg::t_coord lo [3];
    lc3_pkg::t_coord hi [3];
    logic signed [MW-1:0] d [3];
    logic [5:0] code0, code1, oc;
    logic       n_who;
    logic [1:0] n_ax;
    lc3_pkg::t_coord n_plane;
    logic signed [MW-1:0] d_ax, d_c;
    lc3_pkg::t_coord p0_c, p0_ax;
    logic [MW:0] div_t;
    logic signed [SW-1:0] qs, sum;
    lc3_pkg::t_coord sat_v;

    function automatic logic [5:0] outcode(input lc3_pkg::t_coord p [3],
                                           input lc3_pkg::t_coord l [3],
                                           input lc3_pkg::t_coord h [3]);
        logic [5:0] c;
        c = '0;
        for (int a = 0; a < 3; a++) begin
            if (p[a] < l[a]) begin
                c[2*a] = 1'b1;
            end else if (p[a] > h[a]) begin
                c[2*a+1] = 1'b1;
            end
        end
        return c;
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
        return v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lo[a] = (i_min[a] < i_max[a]) ? i_min[a] : i_max[a];
            hi[a] = (i_min[a] < i_max[a]) ? i_max[a] : i_min[a];
            d[a]  = {r_p1[a][CW-1], r_p1[a]} - {r_p0[a][CW-1], r_p0[a]};
        end
        code0 = outcode(r_p0, lo, hi);
        code1 = outcode(r_p1, lo, hi);
        n_who = (code0 == 6'd0);
        oc    = n_who ? code1 : code0;
        // Planes are tried far, near, top, bottom, right, left.
        priority if (oc[5]) begin
            n_ax = 2'd2; n_plane = hi[2];
        end else if (oc[4]) begin
            n_ax = 2'd2; n_plane = lo[2];
        end else if (oc[3]) begin
            n_ax = 2'd1; n_plane = hi[1];
        end else if (oc[2]) begin
            n_ax = 2'd1; n_plane = lo[1];
        end else if (oc[1]) begin
            n_ax = 2'd0; n_plane = hi[0];
        end else begin
            n_ax = 2'd0; n_plane = lo[0];
        end
        unique case (n_ax)
            2'd0:    begin p0_ax = r_p0[0]; d_ax = d[0]; end
            2'd1:    begin p0_ax = r_p0[1]; d_ax = d[1]; end
            default: begin p0_ax = r_p0[2]; d_ax = d[2]; end
        endcase
        unique case (i_cmd.sel)
            2'd0:    begin p0_c = r_p0[0]; d_c = d[0]; end
            2'd1:    begin p0_c = r_p0[1]; d_c = d[1]; end
            default: begin p0_c = r_p0[2]; d_c = d[2]; end
        endcase
        div_t = {r_rem, r_prod[PW-1]};
        qs    = (r_dax == '0) ? '0 : SW'({1'b0, r_prod[lc3_pkg::QMASK_W-1:0]});
        sum   = {{(SW-CW){p0_c[CW-1]}}, p0_c} + (r_neg ? -qs : qs);
        if (sum > SW'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
            sat_v = {1'b0, {(CW-1){1'b1}}};
        end else if (sum < -SW'(signed'({1'b0, 1'b1, {(CW-1){1'b0}}}))) begin
            sat_v = {1'b1, {(CW-1){1'b0}}};
        end else begin
            sat_v = sum[CW-1:0];
        end
    end

    assign o_sts.all_in   = (code0 == 6'd0) && (code1 == 6'd0);
    assign o_sts.disjoint = |(code0 & code1);
    assign o_sts.out_held = r_valid && i_stall;
    assign o_sts.ax       = r_ax;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p0 <= i_in0;
            r_p1 <= i_in1;
        end
        if (i_cmd.pick) begin
            r_who   <= n_who;
            r_ax    <= n_ax;
            r_plane <= n_plane;
            r_num   <= {n_plane[CW-1], n_plane} - {p0_ax[CW-1], p0_ax};
            r_dax   <= mag(d_ax);
            r_np[0] <= r_p0[0];
            r_np[1] <= r_p0[1];
            r_np[2] <= r_p0[2];
        end
        if (i_cmd.mul_start) begin
            r_ma   <= PW'(mag(d_c));
            r_mb   <= mag(r_num);
            r_prod <= '0;
            r_rem  <= '0;
            r_neg  <= (d_c[MW-1] ^ r_num[MW-1]) ^ (r_dax != '0 && r_p1[r_ax] < r_p0[r_ax]);
        end
        if (i_cmd.mul_step) begin
            if (r_mb[0]) begin
                r_prod <= r_prod + r_ma;
            end
            r_ma <= {r_ma[PW-2:0], 1'b0};
            r_mb <= {1'b0, r_mb[MW-1:1]};
        end
        if (i_cmd.div_step) begin
            // Restoring division: one quotient bit per cycle.
            if (div_t >= {1'b0, r_dax}) begin
                r_rem  <= MW'(div_t - {1'b0, r_dax});
                r_prod <= {r_prod[PW-2:0], 1'b1};
            end else begin
                r_rem  <= div_t[MW-1:0];
                r_prod <= {r_prod[PW-2:0], 1'b0};
            end
        end
        if (i_cmd.store) begin
            unique case (i_cmd.sel)
                2'd0:    r_np[0] <= sat_v;
                2'd1:    r_np[1] <= sat_v;
                default: r_np[2] <= sat_v;
            endcase
        end
        if (i_cmd.commit) begin
            for (int a = 0; a < 3; a++) begin
                if (r_who) begin
                    r_p1[a] <= (r_ax == 2'(a)) ? r_plane : r_np[a];
                end else begin
                    r_p0[a] <= (r_ax == 2'(a)) ? r_plane : r_np[a];
                end
            end
        end
        if (i_cmd.out_load) begin
            r_acc <= i_cmd.acc;
            for (int a = 0; a < 3; a++) begin
                r_o0[a] <= i_cmd.acc ? r_p0[a] : '0;
                r_o1[a] <= i_cmd.acc ? r_p1[a] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid    = r_valid;
    assign o_accepted = r_acc;
    assign o_p0       = r_o0;
    assign o_p1       = r_o1;
endmodule

// File: design/lc3_ctrl.sv
// Controller state machine for the line clipper passes and the serial arithmetic.
`timescale 1ns / 1ps
module lc3_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  lc3_pkg::t_sts i_sts,
    output lc3_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_SEL    = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_STORE  = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]                  r_state, n_state;
    logic [lc3_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [lc3_pkg::PASS_W-1:0]  r_pass, n_pass;
    logic [1:0]                  r_c, n_c;
    logic                        r_acc, n_acc;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pass  = r_pass;
        n_c     = r_c;
        n_acc   = r_acc;
        o_cmd   = '0;
        o_cmd.sel = r_c;
        o_cmd.acc = r_acc;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_pass     = '0;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.all_in) begin
                    n_acc   = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.disjoint ||
                             r_pass == lc3_pkg::PASS_W'(lc3_pkg::MAX_PASSES)) begin
                    n_acc   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.pick = 1'b1;
                    n_c        = 2'd0;
                    n_state    = S_SEL;
                end
            end
            S_SEL: begin
                if (r_c == 2'd3) begin
                    n_state = S_COMMIT;
                end else if (r_c == i_sts.ax) begin
                    n_c = r_c + 2'd1;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == lc3_pkg::CNT_W'(lc3_pkg::MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == lc3_pkg::CNT_W'(lc3_pkg::DIV_STEPS - 1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_c         = r_c + 2'd1;
                n_state     = S_SEL;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_pass       = r_pass + 1'b1;
                n_state      = S_EVAL;
            end
            S_DONE: begin
                if (!i_sts.out_held) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pass  <= '0;
            r_c     <= '0;
            r_acc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
            r_c     <= n_c;
            r_acc   <= n_acc;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    a_pass_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass <= lc3_pkg::PASS_W'(lc3_pkg::MAX_PASSES))
        else $error("pass count beyond limit");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_held)
        else $error("result word overwritten while held");
    a_no_axis_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_start |-> (r_c != i_sts.ax))
        else $error("crossing axis sent through the divider");
    a_store_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STORE |-> $past(r_state) == S_DIV)
        else $error("store without a finished division");
endmodule

// File: design/line_clip_3d_outcode_top.sv
// Top level of the 3D outcode line clipper: box registers, controller and datapath.
// Flow: a segment is loaded and evaluated and, when no clip pass is needed, its result is
// sent to the output register. Each clip pass works two coordinates, each through select,
// serial multiply, serial divide and store, plus pass control, on one shared serial unit.
// Throughput: one segment at a time; at most six passes. The result
// word sits in an output register, so a new segment starts while it waits.
// Reset (synchronous, active low) clears control state and sets the box to +/-1.0.
`timescale 1ns / 1ps
module line_clip_3d_outcode_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [31:0]     i_start_x,
    input  logic signed [31:0]     i_start_y,
    input  logic signed [31:0]     i_start_z,
    input  logic signed [31:0]     i_end_x,
    input  logic signed [31:0]     i_end_y,
    input  logic signed [31:0]     i_end_z,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_accepted,
    output logic signed [31:0]     o_clip_start_x,
    output logic signed [31:0]     o_clip_start_y,
    output logic signed [31:0]     o_clip_start_z,
    output logic signed [31:0]     o_clip_end_x,
    output logic signed [31:0]     o_clip_end_y,
    output logic signed [31:0]     o_clip_end_z,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic signed [31:0]     i_cfg_data
);
    localparam lc3_pkg::t_coord ONE = lc3_pkg::t_coord'(1) <<< lc3_pkg::FRAC_BITS;

    lc3_pkg::t_coord r_min [3];
    lc3_pkg::t_coord r_max [3];
    lc3_pkg::t_coord in0 [3];
    lc3_pkg::t_coord in1 [3];
    lc3_pkg::t_coord out0 [3];
    lc3_pkg::t_coord out1 [3];
    lc3_pkg::t_cmd   cmd;
    lc3_pkg::t_sts   sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= -ONE;
                r_max[a] <= ONE;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lc3_pkg::REG_X_MIN: r_min[0] <= i_cfg_data;
                lc3_pkg::REG_Y_MIN: r_min[1] <= i_cfg_data;
                lc3_pkg::REG_Z_MIN: r_min[2] <= i_cfg_data;
                lc3_pkg::REG_X_MAX: r_max[0] <= i_cfg_data;
                lc3_pkg::REG_Y_MAX: r_max[1] <= i_cfg_data;
                lc3_pkg::REG_Z_MAX: r_max[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in0[0] = i_start_x;
    assign in0[1] = i_start_y;
    assign in0[2] = i_start_z;
    assign in1[0] = i_end_x;
    assign in1[1] = i_end_y;
    assign in1[2] = i_end_z;

    lc3_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lc3_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_min      (r_min),
        .i_max      (r_max),
        .i_in0      (in0),
        .i_in1      (in1),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_accepted (o_accepted),
        .o_p0       (out0),
        .o_p1       (out1)
    );

    assign o_clip_start_x = out0[0];
    assign o_clip_start_y = out0[1];
    assign o_clip_start_z = out0[2];
    assign o_clip_end_x   = out1[0];
    assign o_clip_end_y   = out1[1];
    assign o_clip_end_z   = out1[2];
endmodule

// File: tb/sv/lc3_clip_checker.sv
// Checker for the 3D outcode line clipper: tracks the box, predicts each clip and compares.
`timescale 1ns / 1ps
module lc3_clip_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_in_stall,
    input  lc3_pkg::t_coord i_seg [6],
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  logic            i_accepted,
    input  lc3_pkg::t_coord i_clip [6],
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  lc3_pkg::t_coord i_cfg_data,
    output int              o_clip_errors,
    output int              o_clips_pending
);
    typedef longint t_vec3 [3];

    typedef struct {
        logic            acc;
        lc3_pkg::t_coord c [6];
    } t_clip_word;

    localparam longint COORD_HI = 64'sd2147483647;
    localparam longint COORD_LO = -64'sd2147483648;

    longint box_min [3];
    longint box_max [3];
    t_clip_word expected_clips [$];

    function automatic longint sat_coord(longint v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    // Exact product, truncating divide; the quotient keeps 62 bits as the serial unit does.
    function automatic longint scale_delta(longint a, longint b, longint d);
        logic neg;
        logic [127:0] ua, ub, ud, q;
        neg = ((a < 0) != (b < 0)) != (d < 0);
        ua = (a < 0) ? 128'(-a) : 128'(a);
        ub = (b < 0) ? 128'(-b) : 128'(b);
        ud = (d < 0) ? 128'(-d) : 128'(d);
        if (ud == 0) return 0;
        q = (ua * ub) / ud;
        q = q & ((128'd1 << 62) - 1);
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [5:0] region(t_vec3 p, t_vec3 lo, t_vec3 hi);
        logic [5:0] code;
        code = '0;
        for (int a = 0; a < 3; a++) begin
            if (p[a] < lo[a]) code[2*a] = 1'b1;
            else if (p[a] > hi[a]) code[2*a+1] = 1'b1;
        end
        return code;
    endfunction

    function automatic t_clip_word clip_segment(lc3_pkg::t_coord seg [6]);
        t_clip_word res;
        t_vec3 lo, hi, p0, p1, np;
        logic [5:0] c0, c1, oc;
        longint plane, num;
        int ax;
        logic who;
        res.acc = 1'b0;
        for (int a = 0; a < 3; a++) begin
            lo[a] = (box_min[a] < box_max[a]) ? box_min[a] : box_max[a];
            hi[a] = (box_min[a] < box_max[a]) ? box_max[a] : box_min[a];
            p0[a] = seg[a];
            p1[a] = seg[3+a];
        end
        c0 = region(p0, lo, hi);
        c1 = region(p1, lo, hi);
        for (int pass = 0; pass <= lc3_pkg::MAX_PASSES; pass++) begin
            if (c0 == 0 && c1 == 0) begin
                res.acc = 1'b1;
                break;
            end
            if ((c0 & c1) != 0 || pass == lc3_pkg::MAX_PASSES) break;
            who = (c0 == 0);
            oc = who ? c1 : c0;
            ax = -1;
            plane = 0;
            // Far before near, then top, bottom, right, left.
            for (int a = 2; a >= 0 && ax < 0; a--) begin
                if (oc[2*a+1]) begin
                    ax = a;
                    plane = hi[a];
                end else if (oc[2*a]) begin
                    ax = a;
                    plane = lo[a];
                end
            end
            if (ax < 0) break;
            num = plane - p0[ax];
            for (int c = 0; c < 3; c++)
                np[c] = (c == ax) ? plane
                        : sat_coord(p0[c] + scale_delta(p1[c] - p0[c], num, p1[ax] - p0[ax]));
            if (who) begin
                p1 = np;
                c1 = region(p1, lo, hi);
            end else begin
                p0 = np;
                c0 = region(p0, lo, hi);
            end
        end
        for (int a = 0; a < 3; a++) begin
            res.c[a]   = res.acc ? lc3_pkg::t_coord'(p0[a]) : '0;
            res.c[3+a] = res.acc ? lc3_pkg::t_coord'(p1[a]) : '0;
        end
        return res;
    endfunction

    assign o_clips_pending = expected_clips.size();

    always @(posedge i_clk) begin
        t_clip_word want;
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                box_min[a] = -(64'sd1 << lc3_pkg::FRAC_BITS);
                box_max[a] = 64'sd1 << lc3_pkg::FRAC_BITS;
            end
            expected_clips.delete();
            o_clip_errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_clips.size() == 0) begin
                    $display("%0t: result word with no segment outstanding", $time);
                    o_clip_errors++;
                end else begin
                    want = expected_clips.pop_front();
                    if (want.acc !== i_accepted) begin
                        $display("%0t: accepted exp %0d got %0d", $time, want.acc, i_accepted);
                        o_clip_errors++;
                    end
                    for (int k = 0; k < 6; k++)
                        if (want.c[k] !== i_clip[k]) begin
                            $display("%0t: coord %0d exp %h got %h",
                                     $time, k, want.c[k], i_clip[k]);
                            o_clip_errors++;
                        end
                end
            end
            if (i_valid && !i_in_stall)
                expected_clips.push_back(clip_segment(i_seg));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lc3_pkg::REG_X_MIN: box_min[0] = i_cfg_data;
                    lc3_pkg::REG_Y_MIN: box_min[1] = i_cfg_data;
                    lc3_pkg::REG_Z_MIN: box_min[2] = i_cfg_data;
                    lc3_pkg::REG_X_MAX: box_max[0] = i_cfg_data;
                    lc3_pkg::REG_Y_MAX: box_max[1] = i_cfg_data;
                    lc3_pkg::REG_Z_MAX: box_max[2] = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the 3D outcode line clipper: stimulus, box settings and verdict.
`timescale 1ns / 1ps
module tb_top;
    localparam int UNIT = 1 << lc3_pkg::FRAC_BITS;
    localparam lc3_pkg::t_coord CMAX = 32'sh7fffffff;
    localparam lc3_pkg::t_coord CMIN = 32'sh80000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    lc3_pkg::t_coord seg [6] = '{default: '0};
    logic o_valid;
    logic i_stall = 1'b1;
    logic o_accepted;
    lc3_pkg::t_coord clip [6];
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    lc3_pkg::t_coord i_cfg_data = '0;
    int clip_errors;
    int clips_pending;
    int send_gap_max = 0;
    int recv_gap_max = 0;
    bit long_hold_req = 0;

    always #5 i_clk = ~i_clk;

    line_clip_3d_outcode_top i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_start_x(seg[0]), .i_start_y(seg[1]), .i_start_z(seg[2]),
        .i_end_x(seg[3]), .i_end_y(seg[4]), .i_end_z(seg[5]),
        .o_valid, .i_stall, .o_accepted,
        .o_clip_start_x(clip[0]), .o_clip_start_y(clip[1]), .o_clip_start_z(clip[2]),
        .o_clip_end_x(clip[3]), .o_clip_end_y(clip[4]), .o_clip_end_z(clip[5]),
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    lc3_clip_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_seg(seg),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_accepted(o_accepted),
        .i_clip(clip), .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .o_clip_errors(clip_errors), .o_clips_pending(clips_pending)
    );

    task automatic send_segment(lc3_pkg::t_coord sx, lc3_pkg::t_coord sy, lc3_pkg::t_coord sz,
                                lc3_pkg::t_coord ex, lc3_pkg::t_coord ey, lc3_pkg::t_coord ez);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        seg <= '{sx, sy, sz, ex, ey, ez};
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (clips_pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_box(lc3_pkg::t_coord xl, lc3_pkg::t_coord yl, lc3_pkg::t_coord zl,
                             lc3_pkg::t_coord xh, lc3_pkg::t_coord yh, lc3_pkg::t_coord zh);
        lc3_pkg::t_coord vals [6];
        logic [2:0] idx [6];
        vals = '{xl, yl, zl, xh, yh, zh};
        idx = '{lc3_pkg::REG_X_MIN, lc3_pkg::REG_Y_MIN, lc3_pkg::REG_Z_MIN,
                lc3_pkg::REG_X_MAX, lc3_pkg::REG_Y_MAX, lc3_pkg::REG_Z_MAX};
        drain();
        for (int k = 0; k < 6; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data <= vals[k];
            i_cfg_valid <= 1'b1;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly near the box so that clip passes happen; now and then a full-range value.
    function automatic lc3_pkg::t_coord pick_coord(int span);
        if ($urandom_range(0, 9) < 2) return lc3_pkg::t_coord'($urandom);
        return lc3_pkg::t_coord'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic lc3_pkg::t_coord pick_bound(int span);
        return lc3_pkg::t_coord'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_segments(int count, int span);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
                recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
            end
            send_segment(pick_coord(span), pick_coord(span), pick_coord(span),
                         pick_coord(span), pick_coord(span), pick_coord(span));
        end
    endtask

    // Receiver: a random hold before each word, and one long hold on request.
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = long_hold_req ? 3000 : $urandom_range(0, recv_gap_max);
            long_hold_req = 0;
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed segments against the reset box of plus or minus one.
        send_segment(0, 0, 0, UNIT / 2, -UNIT / 2, UNIT / 3);
        send_segment(2 * UNIT, 0, 0, 3 * UNIT, UNIT / 2, 0);
        send_segment(0, 0, 3 * UNIT, 0, 0, 0);
        send_segment(0, 0, -3 * UNIT, UNIT / 4, 0, 0);
        send_segment(0, 3 * UNIT, 0, 0, 0, UNIT / 5);
        send_segment(UNIT / 7, -3 * UNIT, 0, 0, 0, 0);
        send_segment(3 * UNIT, UNIT / 3, 0, 0, 0, 0);
        send_segment(-3 * UNIT, 0, UNIT / 9, 0, 0, 0);
        send_segment(0, 0, 0, 5 * UNIT, -7 * UNIT, 2 * UNIT);
        send_segment(-3 * UNIT, -3 * UNIT, -3 * UNIT, 3 * UNIT, 3 * UNIT, 3 * UNIT);
        send_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        send_segment(CMIN, 0, 0, CMAX, 0, 0);
        send_segment(CMAX, CMIN, 0, UNIT + 1, UNIT / 2, 0);
        send_segment(3 * UNIT, 0, 0, 0, 3 * UNIT, 0);
        send_segment(UNIT, UNIT, UNIT, -UNIT, -UNIT, -UNIT);
        send_segment(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_segment(CMIN, CMAX, 0, CMAX, CMIN, 1);

        // Swapped bounds on every axis.
        write_box(2 * UNIT, 2 * UNIT, 2 * UNIT, -2 * UNIT, -2 * UNIT, -2 * UNIT);
        send_segment(-5 * UNIT, 0, 0, 5 * UNIT, UNIT, -UNIT);
        send_segment(0, 0, 0, 0, 9 * UNIT, 0);
        send_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        random_segments(120, 4 * UNIT);

        // Widest box: everything is inside.
        write_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        send_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        random_segments(60, 4 * UNIT);

        // Flat box at the lowest value, then one at the highest.
        write_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        send_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        send_segment(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        random_segments(40, 4 * UNIT);
        write_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        random_segments(40, 4 * UNIT);

        // Back to the reset bounds, with the long receiver hold to fill the pipe.
        write_box(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT);
        long_hold_req = 1;
        send_gap_max = 0;
        for (int n = 0; n < 6; n++)
            send_segment(0, 0, 3 * UNIT, UNIT / 2, UNIT / 3, 0);
        random_segments(200, 4 * UNIT);
        drain();
        random_segments(120, 4 * UNIT);

        // Random boxes of random size.
        for (int b = 0; b < 5; b++) begin
            write_box(pick_bound(8 * UNIT), pick_bound(8 * UNIT), pick_bound(8 * UNIT),
                      pick_bound(8 * UNIT), pick_bound(8 * UNIT), pick_bound(8 * UNIT));
            random_segments(50, 12 * UNIT);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (clip_errors == 0 && clips_pending == 0) begin
            $display("line_clip_3d_outcode_top test passed");
        end else begin
            $display("line_clip_3d_outcode_top test failed");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("line_clip_3d_outcode_top test failed");
        $finish;
    end
endmodule

// File: sim.f
design/lc3_pkg.sv
design/lc3_dp.sv
design/lc3_ctrl.sv
design/line_clip_3d_outcode_top.sv
tb/sv/lc3_clip_checker.sv
tb/sv/tb_top.sv
